[design/iate_pkg.sv]
// shared types, codes and defaults for the infix token evaluator
package iate_pkg;

    localparam int IATE_VALUE_BITS = 48;
    localparam int IATE_FRAC_BITS  = 16;

    // token kinds
    localparam logic [2:0] OP_NUMBER = 3'd0;
    localparam logic [2:0] OP_PLUS   = 3'd1;
    localparam logic [2:0] OP_MINUS  = 3'd2;
    localparam logic [2:0] OP_TIMES  = 3'd3;
    localparam logic [2:0] OP_DIVIDE = 3'd4;
    localparam logic [2:0] OP_END    = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_FMT  = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // pending multiplicative operator
    localparam logic [1:0] MUL_NONE   = 2'd0;
    localparam logic [1:0] MUL_TIMES  = 2'd1;
    localparam logic [1:0] MUL_DIVIDE = 2'd2;

    typedef struct packed {
        logic       load;
        logic       mul_start;
        logic       div_start;
        logic       div_zero;
        logic       fold;
        logic       set_sign;
        logic       sign_val;
        logic       set_mul;
        logic [1:0] mul_val;
        logic       emit;
        logic       emit_bad;
        logic       clear;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mul_op;
        logic       num_zero;
        logic       mdu_done;
    } t_stat;

endpackage

[design/iate_mdu.sv]
// iterative multiply and divide unit, one bit per cycle, saturating result
module iate_mdu #(
    parameter int VALUE_BITS = 48,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start_mul,
    input  logic                         i_start_div,
    input  logic signed [VALUE_BITS-1:0] i_a,
    input  logic signed [VALUE_BITS-1:0] i_b,
    output logic                         o_done,
    output logic signed [VALUE_BITS-1:0] o_value,
    output logic                         o_ovf
);
    localparam int V  = VALUE_BITS;
    localparam int F  = FRAC_BITS;
    localparam int QW = V + F;
    localparam int PW = 2 * V;
    localparam int MW = (2 * V - F > V + F) ? 2 * V - F : V + F;
    localparam int CW = $clog2(V + F + 1);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_MUL  = 2'd1;
    localparam logic [1:0] M_DIV  = 2'd2;
    localparam logic [1:0] M_FIN  = 2'd3;

    localparam logic [V-1:0] MAG_MIN = {1'b1, {(V-1){1'b0}}};
    localparam logic [V-1:0] MAG_MAX = {1'b0, {(V-1){1'b1}}};

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_is_div, n_is_div;
    logic          r_neg, n_neg;
    logic [V-1:0]  r_x, n_x;
    logic [PW-1:0] r_prod, n_prod;
    logic [V-1:0]  r_rem, n_rem;
    logic [QW-1:0] r_quo, n_quo;

    logic [V-1:0]  mag_a, mag_b;
    logic [V:0]    mul_sum;
    logic [V:0]    div_t;
    logic [V+1:0]  div_diff;
    logic          div_ge;
    logic [MW-1:0] fin_m;
    logic          hi_nz, lo_nz;
    logic [V-1:0]  fin_mag;

    assign mag_a = i_a[V-1] ? (~i_a + 1'b1) : i_a;
    assign mag_b = i_b[V-1] ? (~i_b + 1'b1) : i_b;

    assign mul_sum  = {1'b0, r_prod[PW-1:V]} + (r_prod[0] ? {1'b0, r_x} : {(V+1){1'b0}});
    assign div_t    = {r_rem, r_quo[QW-1]};
    assign div_diff = {1'b0, div_t} - {2'b00, r_x};
    assign div_ge   = !div_diff[V+1];

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_is_div = r_is_div;
        n_neg    = r_neg;
        n_x      = r_x;
        n_prod   = r_prod;
        n_rem    = r_rem;
        n_quo    = r_quo;
        unique case (r_state)
            M_IDLE: begin
                n_neg = i_a[V-1] ^ i_b[V-1];
                if (i_start_mul) begin
                    n_state  = M_MUL;
                    n_is_div = 1'b0;
                    n_x      = mag_a;
                    n_prod   = {{V{1'b0}}, mag_b};
                    n_cnt    = CW'(V);
                end else if (i_start_div) begin
                    n_state  = M_DIV;
                    n_is_div = 1'b1;
                    n_x      = mag_b;
                    n_rem    = '0;
                    n_quo    = QW'(mag_a) << F;
                    n_cnt    = CW'(QW);
                end
            end
            M_MUL: begin
                n_prod = {mul_sum, r_prod[V-1:1]};
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_state = M_FIN;
                end
            end
            M_DIV: begin
                n_rem = div_ge ? div_diff[V-1:0] : div_t[V-1:0];
                n_quo = {r_quo[QW-2:0], div_ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_state = M_FIN;
                end
            end
            M_FIN: begin
                n_state = M_IDLE;
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase
    end

    // exact magnitude, then clamp to the signed range
    assign fin_m = r_is_div ? MW'(r_quo) : MW'(r_prod[PW-1:F]);
    assign hi_nz = |fin_m[MW-1:V];
    assign lo_nz = |fin_m[V-2:0];

    always_comb begin
        if (r_neg) begin
            o_ovf   = hi_nz || (fin_m[V-1] && lo_nz);
            fin_mag = o_ovf ? MAG_MIN : fin_m[V-1:0];
            o_value = ~fin_mag + 1'b1;
        end else begin
            o_ovf   = hi_nz || fin_m[V-1];
            fin_mag = o_ovf ? MAG_MAX : fin_m[V-1:0];
            o_value = fin_mag;
        end
    end

    assign o_done = (r_state == M_FIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_is_div <= n_is_div;
        r_neg    <= n_neg;
        r_x      <= n_x;
        r_prod   <= n_prod;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
    end

endmodule

[design/iate_dpath.sv]
// datapath: sum and product accumulators, pending operators, fault and result registers
module iate_dpath #(
    parameter int VALUE_BITS = 48,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  iate_pkg::t_cmd               i_cmd,
    output iate_pkg::t_stat              o_stat,
    input  logic signed [VALUE_BITS-1:0] i_number_value,
    output logic signed [VALUE_BITS-1:0] o_result_value,
    output logic [1:0]                   o_status
);
    import iate_pkg::*;

    localparam int V = VALUE_BITS;
    localparam logic [V-1:0] VAL_MIN = {1'b1, {(V-1){1'b0}}};
    localparam logic [V-1:0] VAL_MAX = {1'b0, {(V-1){1'b1}}};

    logic signed [V-1:0] r_sum, n_sum;
    logic signed [V-1:0] r_prod, n_prod;
    logic                r_add_sign, n_add_sign;
    logic [1:0]          r_mul_op, n_mul_op;
    logic [1:0]          r_fault, n_fault;
    logic signed [V-1:0] r_res;
    logic [1:0]          r_stat;

    logic                mdu_done, mdu_ovf;
    logic signed [V-1:0] mdu_value;
    logic [V:0]          fold_raw;
    logic                fold_ovf;
    logic [V-1:0]        fold_sum;
    logic [V-1:0]        div0_value;
    logic [1:0]          fault_code;

    iate_mdu #(
        .VALUE_BITS(VALUE_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_mdu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start_mul(i_cmd.mul_start),
        .i_start_div(i_cmd.div_start),
        .i_a        (r_prod),
        .i_b        (i_number_value),
        .o_done     (mdu_done),
        .o_value    (mdu_value),
        .o_ovf      (mdu_ovf)
    );

    // one extra bit catches the wrap of the saturating add
    assign fold_raw = r_add_sign ? ({r_sum[V-1], r_sum} - {r_prod[V-1], r_prod})
                                 : ({r_sum[V-1], r_sum} + {r_prod[V-1], r_prod});
    assign fold_ovf = fold_raw[V] != fold_raw[V-1];
    assign fold_sum = fold_ovf ? (fold_raw[V] ? VAL_MIN : VAL_MAX) : fold_raw[V-1:0];

    assign div0_value = (r_prod == '0) ? '0 : (r_prod[V-1] ? VAL_MIN : VAL_MAX);

    always_comb begin
        fault_code = ST_OK;
        if (i_cmd.fold && fold_ovf) begin
            fault_code = ST_OVERFLOW;
        end else if (i_cmd.div_zero) begin
            fault_code = ST_DIV_ZERO;
        end else if (mdu_done && mdu_ovf) begin
            fault_code = ST_OVERFLOW;
        end
    end

    always_comb begin
        n_sum      = r_sum;
        n_prod     = r_prod;
        n_add_sign = r_add_sign;
        n_mul_op   = r_mul_op;
        // first fault of the expression wins
        n_fault    = (r_fault == ST_OK) ? fault_code : r_fault;
        if (i_cmd.load) begin
            n_prod = i_number_value;
        end
        if (i_cmd.div_zero) begin
            n_prod = div0_value;
        end
        if (mdu_done) begin
            n_prod = mdu_value;
        end
        if (i_cmd.fold) begin
            n_sum = fold_sum;
        end
        if (i_cmd.set_sign) begin
            n_add_sign = i_cmd.sign_val;
        end
        if (i_cmd.set_mul) begin
            n_mul_op = i_cmd.mul_val;
        end
        if (i_cmd.clear) begin
            n_sum      = '0;
            n_prod     = '0;
            n_add_sign = 1'b0;
            n_mul_op   = MUL_NONE;
            n_fault    = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_prod     <= '0;
            r_add_sign <= 1'b0;
            r_mul_op   <= MUL_NONE;
            r_fault    <= ST_OK;
        end else begin
            r_sum      <= n_sum;
            r_prod     <= n_prod;
            r_add_sign <= n_add_sign;
            r_mul_op   <= n_mul_op;
            r_fault    <= n_fault;
        end
        if (i_cmd.emit) begin
            if (i_cmd.emit_bad) begin
                r_res  <= '0;
                r_stat <= ST_BAD_FMT;
            end else begin
                r_res  <= i_cmd.fold ? fold_sum : r_sum;
                r_stat <= (r_fault == ST_OK) ? fault_code : r_fault;
            end
        end
    end

    assign o_stat.mul_op   = r_mul_op;
    assign o_stat.num_zero = (i_number_value == '0);
    assign o_stat.mdu_done = mdu_done;

    assign o_result_value = r_res;
    assign o_status       = r_stat;

endmodule

[design/iate_ctrl.sv]
// controller: parse phase, wait for the iterative unit, output valid
module iate_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [2:0]       i_opcode,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output iate_pkg::t_cmd   o_cmd,
    input  iate_pkg::t_stat  i_stat
);
    import iate_pkg::*;

    localparam logic [1:0] S_EXP_NUM = 2'd0;
    localparam logic [1:0] S_EXP_OP  = 2'd1;
    localparam logic [1:0] S_SKIP    = 2'd2;
    localparam logic [1:0] S_BUSY    = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       accept;

    assign o_in_ready = (r_state != S_BUSY) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_EXP_NUM: begin
                if (accept) begin
                    unique case (i_opcode) inside
                        OP_NUMBER: begin
                            o_cmd.set_mul = 1'b1;
                            o_cmd.mul_val = MUL_NONE;
                            unique case (i_stat.mul_op)
                                MUL_TIMES: begin
                                    o_cmd.mul_start = 1'b1;
                                    n_state         = S_BUSY;
                                end
                                MUL_DIVIDE: begin
                                    if (i_stat.num_zero) begin
                                        o_cmd.div_zero = 1'b1;
                                        n_state        = S_EXP_OP;
                                    end else begin
                                        o_cmd.div_start = 1'b1;
                                        n_state         = S_BUSY;
                                    end
                                end
                                default: begin
                                    o_cmd.load = 1'b1;
                                    n_state    = S_EXP_OP;
                                end
                            endcase
                        end
                        OP_PLUS, OP_MINUS, OP_TIMES, OP_DIVIDE, OP_END: begin
                            // operand missing
                            o_cmd.emit     = 1'b1;
                            o_cmd.emit_bad = 1'b1;
                            o_cmd.clear    = 1'b1;
                            n_state        = S_EXP_NUM;
                        end
                        default: ;
                    endcase
                end
            end
            S_EXP_OP: begin
                if (accept) begin
                    unique case (i_opcode) inside
                        OP_NUMBER: begin
                            // expression ends here, drop tokens up to end
                            o_cmd.fold = 1'b1;
                            n_state    = S_SKIP;
                        end
                        OP_PLUS, OP_MINUS: begin
                            o_cmd.fold     = 1'b1;
                            o_cmd.set_sign = 1'b1;
                            o_cmd.sign_val = (i_opcode == OP_MINUS);
                            o_cmd.set_mul  = 1'b1;
                            o_cmd.mul_val  = MUL_NONE;
                            n_state        = S_EXP_NUM;
                        end
                        OP_TIMES, OP_DIVIDE: begin
                            o_cmd.set_mul = 1'b1;
                            o_cmd.mul_val = (i_opcode == OP_TIMES) ? MUL_TIMES : MUL_DIVIDE;
                            n_state       = S_EXP_NUM;
                        end
                        OP_END: begin
                            o_cmd.fold  = 1'b1;
                            o_cmd.emit  = 1'b1;
                            o_cmd.clear = 1'b1;
                            n_state     = S_EXP_NUM;
                        end
                        default: ;
                    endcase
                end
            end
            S_SKIP: begin
                if (accept && (i_opcode == OP_END)) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.clear = 1'b1;
                    n_state     = S_EXP_NUM;
                end
            end
            S_BUSY: begin
                if (i_stat.mdu_done) begin
                    n_state = S_EXP_OP;
                end
            end
            default: begin
                n_state = S_EXP_NUM;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_EXP_NUM;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[design/infix_arith_token_evaluator_top.sv]
// top level of the two-precedence infix token evaluator
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_ready   i_opcode, i_number_value
//  out      output     o_out_valid / i_out_ready o_result_value, o_status
//
// plus, minus, end, a plain number and a number after divide by zero need no wait for the iterative unit
// a number after times runs the shift-add multiplier, one bit a cycle
// a number after divide runs the restoring divider
// reset is synchronous and active low; no clearing pass is needed
// a result waits in the output register; input is held off only while that register
// is full and not being taken, or while the multiply/divide unit runs
module infix_arith_token_evaluator_top #(
    parameter int VALUE_BITS = iate_pkg::IATE_VALUE_BITS,
    parameter int FRAC_BITS  = iate_pkg::IATE_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [2:0]                   i_opcode,
    input  logic signed [VALUE_BITS-1:0] i_number_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [VALUE_BITS-1:0] o_result_value,
    output logic [1:0]                   o_status
);
    import iate_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    iate_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_opcode   (i_opcode),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    iate_dpath #(
        .VALUE_BITS(VALUE_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_number_value(i_number_value),
        .o_result_value(o_result_value),
        .o_status      (o_status)
    );

endmodule

[tb/infix_arith_token_evaluator_top_test.sv]
// token-stream testbench for the infix evaluator, with an expression predictor and result check
localparam int VBITS = iate_pkg::IATE_VALUE_BITS;
localparam int FBITS = iate_pkg::IATE_FRAC_BITS;

typedef logic signed [VBITS-1:0] t_fix;

localparam t_fix FIX_MAX = {1'b0, {(VBITS-1){1'b1}}};
localparam t_fix FIX_MIN = {1'b1, {(VBITS-1){1'b0}}};

typedef enum logic [1:0] {
    PH_NUMBER,
    PH_OPERATOR,
    PH_SKIP
} t_parse_phase;

typedef struct {
    t_fix       value;
    logic [1:0] status;
} t_expr_value;

class t_expr_value_board;
    t_fix          sum_acc;
    t_fix          term_acc;
    bit            sub_pending;
    logic [1:0]    mul_pending;
    t_parse_phase  phase;
    logic [1:0]    first_fault;
    t_expr_value   values_due[$];
    int            errors;
    int            tokens_taken;
    int            status_seen[4];

    function new();
        clear_expr();
    endfunction

    function void clear_expr();
        sum_acc     = '0;
        term_acc    = '0;
        sub_pending = 1'b0;
        mul_pending = iate_pkg::MUL_NONE;
        phase       = PH_NUMBER;
        first_fault = iate_pkg::ST_OK;
    endfunction

    function int pending();
        return values_due.size();
    endfunction

    function void note_fault(logic [1:0] code);
        if (first_fault == iate_pkg::ST_OK) first_fault = code;
    endfunction

    function logic [127:0] magnitude_of(t_fix v);
        logic signed [127:0] w;
        w = v;
        return (w < 0) ? -w : w;
    endfunction

    // signed value from an exact magnitude, saturating to the value range
    function t_fix from_magnitude(bit neg, logic [127:0] mag);
        logic [127:0] limit;
        logic [127:0] neg_mag;
        limit = 128'd1 << (VBITS - 1);
        if (neg) begin
            if (mag > limit) begin
                note_fault(iate_pkg::ST_OVERFLOW);
                mag = limit;
            end
            neg_mag = -mag;
            return neg_mag[VBITS-1:0];
        end
        if (mag > limit - 1) begin
            note_fault(iate_pkg::ST_OVERFLOW);
            return FIX_MAX;
        end
        return mag[VBITS-1:0];
    endfunction

    function t_fix mul_fixed(t_fix a, t_fix b);
        logic [127:0] prod;
        prod = (magnitude_of(a) * magnitude_of(b)) >> FBITS;
        return from_magnitude((a < 0) != (b < 0), prod);
    endfunction

    function t_fix div_fixed(t_fix a, t_fix b);
        logic [127:0] quot;
        if (b == 0) begin
            note_fault(iate_pkg::ST_DIV_ZERO);
            if (a == 0) return '0;
            return (a > 0) ? FIX_MAX : FIX_MIN;
        end
        quot = (magnitude_of(a) << FBITS) / magnitude_of(b);
        return from_magnitude((a < 0) != (b < 0), quot);
    endfunction

    function t_fix add_sat(t_fix a, t_fix b, bit sub);
        logic signed [VBITS:0] s;
        if (sub) s = a - b;
        else s = a + b;
        if (s > FIX_MAX) begin
            note_fault(iate_pkg::ST_OVERFLOW);
            return FIX_MAX;
        end
        if (s < FIX_MIN) begin
            note_fault(iate_pkg::ST_OVERFLOW);
            return FIX_MIN;
        end
        return s[VBITS-1:0];
    endfunction

    function void emit_value(t_fix value, logic [1:0] status);
        t_expr_value r;
        r.value  = value;
        r.status = status;
        values_due.push_back(r);
        clear_expr();
    endfunction

    // advance the expression state by one accepted token
    function void take_token(logic [2:0] op, t_fix val);
        tokens_taken++;
        if (op > iate_pkg::OP_END) return;
        case (phase)
            PH_NUMBER: begin
                if (op == iate_pkg::OP_NUMBER) begin
                    case (mul_pending)
                        iate_pkg::MUL_TIMES:  term_acc = mul_fixed(term_acc, val);
                        iate_pkg::MUL_DIVIDE: term_acc = div_fixed(term_acc, val);
                        default:              term_acc = val;
                    endcase
                    mul_pending = iate_pkg::MUL_NONE;
                    phase       = PH_OPERATOR;
                end else begin
                    emit_value('0, iate_pkg::ST_BAD_FMT);
                end
            end
            PH_OPERATOR: begin
                case (op)
                    iate_pkg::OP_NUMBER: begin
                        sum_acc = add_sat(sum_acc, term_acc, sub_pending);
                        phase   = PH_SKIP;
                    end
                    iate_pkg::OP_PLUS, iate_pkg::OP_MINUS: begin
                        sum_acc     = add_sat(sum_acc, term_acc, sub_pending);
                        sub_pending = (op == iate_pkg::OP_MINUS);
                        mul_pending = iate_pkg::MUL_NONE;
                        phase       = PH_NUMBER;
                    end
                    iate_pkg::OP_TIMES: begin
                        mul_pending = iate_pkg::MUL_TIMES;
                        phase       = PH_NUMBER;
                    end
                    iate_pkg::OP_DIVIDE: begin
                        mul_pending = iate_pkg::MUL_DIVIDE;
                        phase       = PH_NUMBER;
                    end
                    default: begin
                        sum_acc = add_sat(sum_acc, term_acc, sub_pending);
                        emit_value(sum_acc, first_fault);
                    end
                endcase
            end
            default: begin
                if (op == iate_pkg::OP_END) emit_value(sum_acc, first_fault);
            end
        endcase
    endfunction

    function void check_value(t_fix value, logic [1:0] status);
        t_expr_value want;
        if (values_due.size() == 0) begin
            $error("result with nothing due: result_value %0d status %0d", value, status);
            errors++;
            return;
        end
        want = values_due.pop_front();
        status_seen[want.status]++;
        if (value !== want.value) begin
            $error("result_value: expected %0d, actual %0d", want.value, value);
            errors++;
        end
        if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            errors++;
        end
    endfunction
endclass

module infix_arith_token_evaluator_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import iate_pkg::*;

    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam t_fix FIX_ONE     = t_fix'(1) << FBITS;
    localparam int   CYCLE_LIMIT = 1_000_000;
    localparam int   TAIL_CYCLES = VBITS + FBITS + 40;
    localparam int   TOKENS_PER_PHASE = 550;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [2:0] opcode = OP_NUMBER;
    t_fix       number_value = '0;
    logic       out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_fix       o_result_value;
    logic [1:0] o_status;

    t_expr_value_board sb = new();
    int send_idle_pct = 13;
    int recv_idle_pct = 58;
    int counted_tokens = 0;
    int cycles = 0;

    infix_arith_token_evaluator_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (opcode),
        .i_number_value (number_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) sb.check_value(o_result_value, o_status);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycles, sb.pending());
            $display("infix_arith_token_evaluator_top verification failed");
            $finish;
        end
    end

    function automatic t_fix rand_bits();
        return t_fix'({$urandom(), $urandom()});
    endfunction

    function automatic t_fix rand_number();
        int pick;
        t_fix v;
        pick = $urandom_range(99);
        if (pick < 10) begin
            v = '0;
        end else if (pick < 18) begin
            case ($urandom_range(3))
                0: v = FIX_MAX;
                1: v = FIX_MIN;
                2: v = t_fix'(1);
                default: v = t_fix'(-1);
            endcase
        end else if (pick < 45) begin
            v = t_fix'(int'($urandom_range(40)) - 20) <<< FBITS;
        end else if (pick < 65) begin
            v = t_fix'(int'($urandom()) >>> $urandom_range(16));
        end else begin
            v = rand_bits();
        end
        return v;
    endfunction

    function automatic logic [2:0] rand_operator();
        case ($urandom_range(3))
            0: return OP_PLUS;
            1: return OP_MINUS;
            2: return OP_TIMES;
            default: return OP_DIVIDE;
        endcase
    endfunction

    task automatic send_token(input logic [2:0] op, input t_fix val);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        number_value <= val;
        do @(posedge i_clk); while (!o_in_ready);
        sb.take_token(op, val);
        if (op <= OP_END) counted_tokens++;
    endtask

    // a stray token of any kind ahead of the intended one, now and then
    task automatic send_noisy(input logic [2:0] op, input t_fix val, input int noise_pct);
        if ($urandom_range(99) < noise_pct) send_token(3'($urandom_range(7)), rand_number());
        send_token(op, val);
    endtask

    task automatic send_expression();
        int terms;
        int noise_pct;
        terms = ($urandom_range(19) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 5);
        noise_pct = ($urandom_range(99) < 20) ? 25 : 0;
        for (int i = 0; i < terms; i++) begin
            if (i != 0) send_noisy(rand_operator(), rand_bits(), noise_pct);
            send_noisy(OP_NUMBER, rand_number(), noise_pct);
        end
        send_noisy(OP_END, rand_bits(), noise_pct);
    endtask

    // hold the sender off until every due result has come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic run_random_phase(input int s_pct, input int r_pct);
        send_idle_pct  = s_pct;
        recv_idle_pct  = r_pct;
        counted_tokens = 0;
        while (counted_tokens < TOKENS_PER_PHASE) send_expression();
        drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // operand missing at the start, and an unused opcode there
        send_token(OP_END, '0);
        send_token(OP_TIMES, FIX_MAX);
        send_token(OP_SPARE_7, FIX_MIN);
        // subtraction past the negative bound
        send_token(OP_NUMBER, FIX_MIN);
        send_token(OP_MINUS, '0);
        send_token(OP_NUMBER, FIX_MAX);
        send_token(OP_END, '0);
        // divide by zero first, then a saturating product: first fault wins
        send_token(OP_NUMBER, 5 * FIX_ONE);
        send_token(OP_DIVIDE, '0);
        send_token(OP_NUMBER, '0);
        send_token(OP_TIMES, '0);
        send_token(OP_NUMBER, FIX_MAX);
        send_token(OP_END, '0);
        // negative dividend over zero
        send_token(OP_NUMBER, t_fix'(-1));
        send_token(OP_DIVIDE, '0);
        send_token(OP_NUMBER, '0);
        send_token(OP_END, '0);
        // number where an operator belongs closes the expression, rest skipped
        send_token(OP_NUMBER, FIX_MAX);
        send_token(OP_PLUS, '0);
        send_token(OP_NUMBER, FIX_ONE);
        send_token(OP_SPARE_6, FIX_MAX);
        send_token(OP_NUMBER, 3 * FIX_ONE);
        send_token(OP_PLUS, '0);
        send_token(OP_SPARE_7, '0);
        send_token(OP_END, '0);

        run_random_phase(13, 58);
        run_random_phase(58, 13);
        run_random_phase(0, 0);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d results never arrived", sb.pending());
            sb.errors++;
        end
        $display("%0d tokens sent, including stray, unused and skipped ones", sb.tokens_taken);
        $display("results by status: ok %0d, bad format %0d, divide by zero %0d, overflow %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_BAD_FMT],
                 sb.status_seen[ST_DIV_ZERO], sb.status_seen[ST_OVERFLOW]);
        if (sb.errors == 0) begin
            $display("infix_arith_token_evaluator_top verification clean");
        end else begin
            $display("infix_arith_token_evaluator_top verification failed");
        end
        $finish;
    end
endmodule
